// ----- rtl/sialu_pkg.sv -----
// Package for the signed integer ALU: operation codes, status codes and
// the operation classes passed from front to back. No dependencies.
`timescale 1ns / 1ps
package sialu_pkg;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_MOD = 4'd4,
        OP_LT  = 4'd5,
        OP_GT  = 4'd6,
        OP_LE  = 4'd7,
        OP_GE  = 4'd8,
        OP_EQ  = 4'd9,
        OP_NE  = 4'd10
    } op_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;

    // Class of work for the back end.
    typedef enum logic [1:0] {
        CLS_FAST = 2'd0,
        CLS_MUL  = 2'd1,
        CLS_DIV  = 2'd2
    } cls_t;

endpackage

// ----- rtl/signed_int_alu_with_divide.sv -----
// Top level of the signed integer ALU: front classifier, back execution
// pipe and output queue. Depends on sialu_pkg and the three submodules.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------
//  input    | push / full        | mode, left_operand, right_operand
//  result   | pop / empty        | result_value, status
//
// One transaction enters per cycle when nothing stalls.
// The path runs through one front register, a setup stage, one divider
// stage per quotient bit, then the output queue.
// Reset clears all valid bits and queue pointers; data registers are not reset.
// Holding pop low backs up the queue, then the execution pipe, then full.
`timescale 1ns / 1ps
module signed_int_alu_with_divide #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [3:0]            mode,
    input  logic [DATA_WIDTH-1:0] left_operand,
    input  logic [DATA_WIDTH-1:0] right_operand,
    output logic                  empty,
    input  logic                  pop,
    output logic [DATA_WIDTH-1:0] result_value,
    output logic [1:0]            status
);
    logic                  f_ready, f_valid, f_mod;
    sialu_pkg::cls_t       f_cls;
    logic [DATA_WIDTH-1:0] f_a, f_b, f_fast;
    logic [1:0]            f_st;
    logic                  b_ready, b_valid, q_ready;
    logic [DATA_WIDTH-1:0] b_value;
    logic [1:0]            b_st;

    assign full = !f_ready;

    sialu_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(push), .mode(mode),
        .left_operand(left_operand), .right_operand(right_operand),
        .out_ready(b_ready), .in_ready(f_ready), .out_valid(f_valid),
        .out_cls(f_cls), .out_is_mod(f_mod), .out_a(f_a), .out_b(f_b),
        .out_fast(f_fast), .out_status(f_st)
    );

    sialu_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f_valid), .in_cls(f_cls), .in_is_mod(f_mod),
        .in_a(f_a), .in_b(f_b), .in_fast(f_fast), .in_status(f_st),
        .in_ready(b_ready), .out_valid(b_valid), .out_value(b_value),
        .out_status(b_st), .out_ready(q_ready)
    );

    sialu_outq #(.DATA_WIDTH(DATA_WIDTH)) u_outq (
        .clk(clk), .rst_n(rst_n),
        .in_valid(b_valid), .in_value(b_value), .in_status(b_st),
        .in_ready(q_ready), .empty(empty), .result_value(result_value),
        .status(status), .pop(pop)
    );

    // Status stays within its three codes.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> status != 2'd3)
        else $error("bad status code");
    // Full is low on the cycle after reset.
    a_full_reset: assert property (@(posedge clk)
        !rst_n |=> !full)
        else $error("full after reset");
    // An empty queue with no incoming result stays empty.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        empty && !b_valid |=> empty)
        else $error("result invented");
endmodule

// ----- rtl/sialu_front.sv -----
// Front end: accept transactions, classify the opcode, settle simple
// operations and errors, and register the item. Depends on sialu_pkg.
`timescale 1ns / 1ps
module sialu_front #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [3:0]            mode,
    input  logic [DATA_WIDTH-1:0] left_operand,
    input  logic [DATA_WIDTH-1:0] right_operand,
    input  logic                  out_ready,
    output logic                  in_ready,
    output logic                  out_valid,
    output sialu_pkg::cls_t       out_cls,
    output logic                  out_is_mod,
    output logic [DATA_WIDTH-1:0] out_a,
    output logic [DATA_WIDTH-1:0] out_b,
    output logic [DATA_WIDTH-1:0] out_fast,
    output logic [1:0]            out_status
);
    logic                  valid_reg;
    sialu_pkg::cls_t       cls_reg, cls_next;
    logic                  mod_reg;
    logic [DATA_WIDTH-1:0] a_reg, b_reg, fast_reg, fast_next;
    logic [1:0]            st_reg, st_next;
    logic                  lt, gt, eq;

    assign in_ready = !valid_reg || out_ready;
    assign lt = $signed(left_operand) < $signed(right_operand);
    assign gt = $signed(right_operand) < $signed(left_operand);
    assign eq = left_operand == right_operand;

    always_comb
    begin
        cls_next  = sialu_pkg::CLS_FAST;
        fast_next = '0;
        st_next   = sialu_pkg::ST_OK;
        case (mode)
            sialu_pkg::OP_ADD: fast_next = left_operand + right_operand;
            sialu_pkg::OP_SUB: fast_next = left_operand - right_operand;
            sialu_pkg::OP_MUL: cls_next = sialu_pkg::CLS_MUL;
            sialu_pkg::OP_DIV, sialu_pkg::OP_MOD:
            begin
                if (right_operand == '0)
                    st_next = sialu_pkg::ST_DIV_ZERO;
                else
                    cls_next = sialu_pkg::CLS_DIV;
            end
            sialu_pkg::OP_LT: fast_next = DATA_WIDTH'(lt);
            sialu_pkg::OP_GT: fast_next = DATA_WIDTH'(gt);
            sialu_pkg::OP_LE: fast_next = DATA_WIDTH'(!gt);
            sialu_pkg::OP_GE: fast_next = DATA_WIDTH'(!lt);
            sialu_pkg::OP_EQ: fast_next = DATA_WIDTH'(eq);
            sialu_pkg::OP_NE: fast_next = DATA_WIDTH'(!eq);
            default: st_next = sialu_pkg::ST_INVALID;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cls_reg  <= cls_next;
            mod_reg  <= (mode == sialu_pkg::OP_MOD);
            a_reg    <= left_operand;
            b_reg    <= right_operand;
            fast_reg <= fast_next;
            st_reg   <= st_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_cls    = cls_reg;
    assign out_is_mod = mod_reg;
    assign out_a      = a_reg;
    assign out_b      = b_reg;
    assign out_fast   = fast_reg;
    assign out_status = st_reg;
endmodule

// ----- rtl/sialu_back.sv -----
// Back end: pipelined multiply and radix-2 divide, one transaction per
// cycle, stalling as a whole. Depends on sialu_pkg.
`timescale 1ns / 1ps
module sialu_back #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  sialu_pkg::cls_t       in_cls,
    input  logic                  in_is_mod,
    input  logic [DATA_WIDTH-1:0] in_a,
    input  logic [DATA_WIDTH-1:0] in_b,
    input  logic [DATA_WIDTH-1:0] in_fast,
    input  logic [1:0]            in_status,
    output logic                  in_ready,
    output logic                  out_valid,
    output logic [DATA_WIDTH-1:0] out_value,
    output logic [1:0]            out_status,
    input  logic                  out_ready
);
    localparam int W = DATA_WIDTH;
    localparam int N = W + 1;   // stage 0 = setup, stages 1..W = quotient bits

    logic                  vld_reg  [N];
    sialu_pkg::cls_t       cls_reg  [N];
    logic                  mod_reg  [N];
    logic                  nq_reg   [N];
    logic                  nr_reg   [N];
    logic [W-1:0]          rem_reg  [N];
    logic [W-1:0]          quo_reg  [N];
    logic [W-1:0]          div_reg  [N];
    logic [W-1:0]          val_reg  [N];
    logic [1:0]            st_reg   [N];
    logic                  adv;

    // Advance the whole pipe unless the final stage is held.
    assign adv       = !vld_reg[N-1] || out_ready;
    assign in_ready  = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < N; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // Setup stage: magnitudes, signs, and the low product.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cls_reg[0] <= in_cls;
            mod_reg[0] <= in_is_mod;
            nq_reg[0]  <= in_a[W-1] ^ in_b[W-1];
            nr_reg[0]  <= in_a[W-1];
            rem_reg[0] <= '0;
            quo_reg[0] <= in_a[W-1] ? W'(-in_a) : in_a;
            div_reg[0] <= in_b[W-1] ? W'(-in_b) : in_b;
            val_reg[0] <= (in_cls == sialu_pkg::CLS_MUL) ? W'(in_a * in_b) : in_fast;
            st_reg[0]  <= in_status;
        end
    end

    // Restoring division, one quotient bit per stage; quo shifts the dividend
    // bits out at the top and the quotient bits in at the bottom.
    for (genvar s = 1; s < N; s++)
    begin : g_div
        logic [W:0] trial;
        logic [W:0] shifted;
        assign shifted = {rem_reg[s-1], quo_reg[s-1][W-1]};
        assign trial   = shifted - {1'b0, div_reg[s-1]};
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cls_reg[s] <= cls_reg[s-1];
                mod_reg[s] <= mod_reg[s-1];
                nq_reg[s]  <= nq_reg[s-1];
                nr_reg[s]  <= nr_reg[s-1];
                div_reg[s] <= div_reg[s-1];
                val_reg[s] <= val_reg[s-1];
                st_reg[s]  <= st_reg[s-1];
                rem_reg[s] <= trial[W] ? shifted[W-1:0] : trial[W-1:0];
                quo_reg[s] <= {quo_reg[s-1][W-2:0], !trial[W]};
            end
        end
    end

    logic [W-1:0] q_fin, r_fin;
    assign q_fin = nq_reg[N-1] ? W'(-quo_reg[N-1]) : quo_reg[N-1];
    assign r_fin = nr_reg[N-1] ? W'(-rem_reg[N-1]) : rem_reg[N-1];

    assign out_valid  = vld_reg[N-1];
    assign out_status = st_reg[N-1];
    assign out_value  = (cls_reg[N-1] != sialu_pkg::CLS_DIV) ? val_reg[N-1]
                      : (mod_reg[N-1] ? r_fin : q_fin);

    // A held output keeps its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value))
        else $error("held result changed");
    // Error status never comes with a nonzero value.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status != sialu_pkg::ST_OK |-> out_value == '0)
        else $error("error result not zero");
    // Stall freezes the pipe entry.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg[0]))
        else $error("pipe moved in stall");
endmodule

// ----- rtl/sialu_outq.sv -----
// Two-entry output queue that parts the back end from the pop side.
// No package dependency.
`timescale 1ns / 1ps
module sialu_outq #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [DATA_WIDTH-1:0] in_value,
    input  logic [1:0]            in_status,
    output logic                  in_ready,
    output logic                  empty,
    output logic [DATA_WIDTH-1:0] result_value,
    output logic [1:0]            status,
    input  logic                  pop
);
    logic [DATA_WIDTH-1:0] val_reg [2];
    logic [1:0]            st_reg  [2];
    logic                  wp_reg, rp_reg;
    logic [1:0]            cnt_reg;
    logic                  wr, rd;

    assign in_ready = cnt_reg != 2'd2;
    assign empty    = cnt_reg == 2'd0;
    assign wr = in_valid && in_ready;
    assign rd = pop && !empty;
    assign result_value = val_reg[rp_reg];
    assign status       = st_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            val_reg[wp_reg] <= in_value;
            st_reg[wp_reg]  <= in_status;
        end
    end
endmodule

// ----- test/tb_signed_int_alu_with_divide.sv -----
// Self-checking testbench for the signed integer ALU with divide.
// Drives operations through the push/full queue, predicts each result and
// checks it at the pop/empty side. Depends on sialu_pkg and the DUT.
`timescale 1ns / 1ps
module tb_signed_int_alu_with_divide;

    localparam int W = 32;
    localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [3:0] MODE_BAD_LO = 4'd11;
    localparam logic [3:0] MODE_BAD_HI = 4'd15;

    typedef struct packed {
        logic [3:0]   mode;
        logic [W-1:0] lhs;
        logic [W-1:0] rhs;
    } alu_op_t;

    typedef struct packed {
        logic [W-1:0] value;
        logic [1:0]   status;
    } alu_res_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         push = 1'b0;
    logic         full;
    logic [3:0]   mode = '0;
    logic [W-1:0] left_operand = '0;
    logic [W-1:0] right_operand = '0;
    logic         empty;
    logic         pop = 1'b0;
    logic [W-1:0] result_value;
    logic [1:0]   status;

    alu_op_t  pending_ops[$];
    alu_res_t expected_results[$];
    int       error_count = 0;
    int       cycle_count = 0;

    signed_int_alu_with_divide #(.DATA_WIDTH(W)) u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .mode(mode),
        .left_operand(left_operand), .right_operand(right_operand),
        .empty(empty), .pop(pop), .result_value(result_value), .status(status)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Compute the expected ALU result for one operation.
    function automatic alu_res_t alu_predict(alu_op_t op);
        alu_res_t r;
        logic signed [W-1:0] a;
        logic signed [W-1:0] b;
        logic [W-1:0] ma;
        logic [W-1:0] mb;
        logic [W-1:0] q;
        logic [W-1:0] rem;
        a = op.lhs;
        b = op.rhs;
        ma = a[W-1] ? -op.lhs : op.lhs;
        mb = b[W-1] ? -op.rhs : op.rhs;
        r.value = '0;
        r.status = sialu_pkg::ST_OK;
        case (op.mode)
            sialu_pkg::OP_ADD: r.value = op.lhs + op.rhs;
            sialu_pkg::OP_SUB: r.value = op.lhs - op.rhs;
            sialu_pkg::OP_MUL: r.value = op.lhs * op.rhs;
            sialu_pkg::OP_DIV, sialu_pkg::OP_MOD:
                if (op.rhs == '0)
                    r.status = sialu_pkg::ST_DIV_ZERO;
                else
                begin
                    // Work on magnitudes, then restore the sign (truncating).
                    q = ma / mb;
                    rem = ma % mb;
                    if (op.mode == sialu_pkg::OP_DIV)
                        r.value = (a[W-1] != b[W-1]) ? -q : q;
                    else
                        r.value = a[W-1] ? -rem : rem;
                end
            sialu_pkg::OP_LT: r.value = W'(a < b);
            sialu_pkg::OP_GT: r.value = W'(a > b);
            sialu_pkg::OP_LE: r.value = W'(a <= b);
            sialu_pkg::OP_GE: r.value = W'(a >= b);
            sialu_pkg::OP_EQ: r.value = W'(a == b);
            sialu_pkg::OP_NE: r.value = W'(a != b);
            default: r.status = sialu_pkg::ST_INVALID;
        endcase
        return r;
    endfunction

    function automatic logic [W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return MOST_NEG;
            1: return MOST_POS;
            2: return '0;
            3: return {W{1'b1}};
            4: return W'($urandom_range(0, 8)) - W'(4);
            5: return W'($urandom_range(0, 65535)) - W'(32768);
            default: return $urandom;
        endcase
    endfunction

    // Driver: present the queue head, advance on an accepted transaction.
    always @(posedge clk)
    begin
        bit idle;
        idle = (cycle_count % 3000 > 2200) ? 1'b0 : ($urandom_range(0, 99) < 24);
        if (rst_n)
        begin
            if (push && !full)
            begin
                expected_results.push_back(alu_predict(pending_ops.pop_front()));
            end
            if ((push && !full) || !push)
            begin
                if (pending_ops.size() != 0 && !idle)
                begin
                    push <= 1'b1;
                    mode <= pending_ops[0].mode;
                    left_operand <= pending_ops[0].lhs;
                    right_operand <= pending_ops[0].rhs;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each popped transaction against the oldest expectation.
    always @(posedge clk)
    begin
        alu_res_t exp_r;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result value=%h status=%0d",
                             $time, result_value, status);
                    error_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (result_value !== exp_r.value)
                    begin
                        $display("%0t: result_value expected %h actual %h",
                                 $time, exp_r.value, result_value);
                        error_count++;
                    end
                    if (status !== exp_r.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_r.status, status);
                        error_count++;
                    end
                end
            end
            // Hold pop steady through a long stretch, otherwise stall at random.
            pop <= (cycle_count % 3000 > 2200) ? 1'b1 : ($urandom_range(0, 99) >= 24);
        end
    end

    initial
    begin
        alu_op_t op;
        logic [W-1:0] corners[4];
        corners = '{MOST_NEG, MOST_POS, '0, {W{1'b1}}};
        // Directed: every mode on corners, the special cases, invalid codes.
        for (int m = 0; m <= 10; m++)
        begin
            op.mode = 4'(m);
            op.lhs = corners[m % 4];
            op.rhs = corners[(m + 1) % 4];
            pending_ops.push_back(op);
        end
        pending_ops.push_back('{sialu_pkg::OP_DIV, MOST_NEG, {W{1'b1}}});
        pending_ops.push_back('{sialu_pkg::OP_MOD, MOST_NEG, {W{1'b1}}});
        pending_ops.push_back('{sialu_pkg::OP_DIV, W'(7), '0});
        pending_ops.push_back('{sialu_pkg::OP_MOD, MOST_NEG, '0});
        pending_ops.push_back('{sialu_pkg::OP_DIV, -W'(7), W'(2)});
        pending_ops.push_back('{sialu_pkg::OP_MOD, -W'(7), W'(2)});
        pending_ops.push_back('{sialu_pkg::OP_MOD, W'(7), -W'(2)});
        pending_ops.push_back('{sialu_pkg::OP_MUL, MOST_POS, MOST_POS});
        pending_ops.push_back('{sialu_pkg::OP_LT, MOST_NEG, MOST_POS});
        pending_ops.push_back('{sialu_pkg::OP_EQ, MOST_POS, MOST_POS});
        pending_ops.push_back('{MODE_BAD_LO, MOST_POS, MOST_NEG});
        pending_ops.push_back('{MODE_BAD_HI, {W{1'b1}}, {W{1'b1}}});
        // Random: mostly valid modes, some invalid.
        for (int i = 0; i < 1950; i++)
        begin
            op.mode = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(11, 15))
                                                 : 4'($urandom_range(0, 10));
            op.lhs = pick_operand();
            op.rhs = pick_operand();
            pending_ops.push_back(op);
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_ops.size() == 0 && !push);
        wait (expected_results.size() == 0);
        repeat (W + 10) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("** signed_int_alu_with_divide: PASSED **");
        else
            $display("** signed_int_alu_with_divide: FAILED **");
        $finish;
    end

    // Stop a hung run.
    initial
    begin
        #2000000;
        $display("** signed_int_alu_with_divide: FAILED **");
        $finish;
    end
endmodule
